### hdl/binary_patch_energy_eval_core_macros.svh
// Shared assertion macros for the energy evaluator.
// Each expects signals named clk and rst in the scope of use.
`ifndef BINARY_PATCH_ENERGY_EVAL_CORE_MACROS_SVH
`define BINARY_PATCH_ENERGY_EVAL_CORE_MACROS_SVH

// Same-cycle implication.
`define BPE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpe assertion failed");

// Next-cycle implication.
`define BPE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpe assertion failed");

`endif

### hdl/bpe_pkg.sv
`default_nettype none

package bpe_pkg;

  localparam int IMAGE_WIDTH_W = 11;
  localparam int SCALE_W       = 16;
  localparam int PIXEL_W       = 8;
  localparam int ENERGY_W      = 63;
  localparam int ADD_W         = 36;
  localparam int ROM_W         = 16;
  localparam int PATTERN_W     = 9;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam int DEFAULT_MAX_WIDTH = 1024;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNARY_SCALE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIQUE_SCALE = 2'd2;

  localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [SCALE_W-1:0]       UNARY_SCALE_RESET  = 16'd256;
  localparam logic [SCALE_W-1:0]       CLIQUE_SCALE_RESET = 16'd256;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // cost of patterns that never occur in clean shapes
  localparam logic [ROM_W-1:0] C_X = 16'd56360;

  typedef struct packed {
    logic add_en;
    logic clear;
  } acc_ctrl_t;

  // Q4.12 patch costs, indexed by the 9-bit window pattern (top-left is bit 0)
  localparam logic [ROM_W-1:0] PATCH_ROM [512] = '{
    16'd10602,16'd22770,16'd37182,16'd26513,16'd22709,16'd45854,16'd26338,16'd20149,
    16'd36360,16'd28385,16'd46929,16'd27238,16'd50682,16'd51860,16'd48390,16'd26822,
    16'd46929,16'd49768,16'd47360,16'd42711,16'd49768,C_X,16'd43517,16'd42294,
    16'd42861,16'd41682,C_X,16'd37929,16'd49021,C_X,16'd49768,16'd26957,
    16'd36751,C_X,16'd47843,16'd50682,16'd28452,C_X,16'd27172,16'd26633,
    C_X,16'd53521,C_X,C_X,C_X,C_X,C_X,16'd48390,
    16'd42429,C_X,C_X,16'd51860,16'd45268,C_X,16'd37665,16'd26673,
    16'd39017,16'd46538,C_X,16'd41354,16'd45004,C_X,16'd43890,16'd19881,
    16'd22717,16'd46182,C_X,C_X,C_X,C_X,C_X,16'd51860,
    16'd28618,16'd23468,16'd49768,16'd28722,C_X,C_X,C_X,16'd45268,
    16'd49021,C_X,C_X,C_X,16'd50682,C_X,16'd49021,C_X,
    16'd42165,16'd43517,16'd49768,16'd28975,16'd53521,C_X,16'd47843,16'd27238,
    16'd50682,C_X,C_X,C_X,C_X,C_X,16'd47843,16'd43176,
    C_X,C_X,C_X,C_X,16'd53521,16'd49021,16'd51860,16'd50682,
    16'd50682,C_X,C_X,C_X,C_X,C_X,16'd50682,16'd42038,
    16'd45551,16'd51860,C_X,16'd47360,16'd53521,C_X,16'd45551,16'd26702,
    16'd37220,16'd51860,C_X,C_X,C_X,C_X,C_X,C_X,
    16'd47843,16'd49768,C_X,C_X,C_X,C_X,C_X,16'd50682,
    16'd43699,C_X,16'd45854,16'd49768,C_X,C_X,16'd51860,C_X,
    16'd53521,16'd46538,C_X,16'd45551,C_X,C_X,C_X,16'd46929,
    16'd48390,C_X,C_X,C_X,16'd49768,C_X,C_X,16'd53521,
    C_X,C_X,C_X,C_X,C_X,C_X,C_X,C_X,
    16'd53521,C_X,C_X,C_X,16'd48390,C_X,16'd45551,16'd47360,
    C_X,C_X,C_X,C_X,C_X,C_X,C_X,16'd42165,
    16'd26354,C_X,C_X,C_X,C_X,C_X,16'd51860,16'd42711,
    16'd27126,16'd28975,C_X,16'd46929,16'd48390,16'd48390,16'd53521,C_X,
    16'd43890,C_X,16'd49021,C_X,16'd51860,C_X,C_X,C_X,
    16'd38843,16'd29228,16'd46182,16'd23508,16'd53521,16'd49768,16'd49021,16'd28641,
    16'd48390,C_X,C_X,C_X,C_X,C_X,16'd49768,16'd42861,
    C_X,C_X,C_X,C_X,16'd49021,16'd51860,16'd47360,C_X,
    16'd49021,C_X,C_X,C_X,16'd46929,C_X,16'd51860,C_X,
    16'd42861,16'd45268,C_X,16'd43343,16'd47360,C_X,16'd44300,16'd23059,
    16'd22795,C_X,16'd51860,C_X,16'd49768,C_X,C_X,16'd51860,
    C_X,C_X,C_X,16'd53521,C_X,C_X,C_X,16'd45004,
    16'd51860,16'd49768,C_X,16'd50682,C_X,C_X,C_X,16'd53521,
    C_X,16'd53521,C_X,16'd49768,C_X,C_X,C_X,16'd41916,
    16'd28408,16'd53521,16'd51860,C_X,16'd23465,C_X,16'd28849,16'd45268,
    C_X,C_X,C_X,C_X,C_X,C_X,C_X,16'd53521,
    16'd41682,C_X,16'd51860,16'd47360,16'd42568,C_X,16'd29042,16'd27221,
    16'd46929,16'd51860,C_X,16'd45551,16'd50682,C_X,16'd47360,16'd26482,
    16'd50682,C_X,C_X,C_X,C_X,C_X,C_X,C_X,
    16'd51860,C_X,C_X,16'd53521,C_X,C_X,C_X,16'd47843,
    C_X,C_X,C_X,C_X,C_X,C_X,C_X,C_X,
    C_X,C_X,C_X,16'd50682,C_X,C_X,C_X,16'd44755,
    C_X,C_X,C_X,C_X,16'd53521,C_X,16'd50682,16'd46929,
    C_X,16'd51860,C_X,16'd50682,16'd53521,16'd46929,16'd51860,16'd50682,
    C_X,C_X,C_X,C_X,C_X,C_X,16'd49768,16'd46538,
    C_X,C_X,C_X,C_X,C_X,C_X,C_X,16'd43343,
    16'd26519,C_X,C_X,C_X,C_X,C_X,16'd53521,16'd44755,
    16'd53521,C_X,C_X,16'd53521,C_X,C_X,C_X,16'd42711,
    16'd43517,16'd53521,16'd49021,C_X,C_X,C_X,C_X,C_X,
    16'd50682,16'd48390,C_X,16'd48390,C_X,C_X,C_X,C_X,
    16'd27211,16'd53521,C_X,16'd49768,16'd28889,16'd51860,16'd49768,C_X,
    C_X,16'd51860,C_X,16'd45854,C_X,16'd49768,C_X,16'd49768,
    16'd38115,16'd50682,16'd44521,16'd49768,16'd29037,16'd53521,16'd23266,16'd28761,
    16'd42294,16'd47843,C_X,16'd42861,16'd46182,C_X,16'd42294,16'd22998,
    16'd20115,C_X,C_X,16'd46538,16'd51860,C_X,16'd43890,16'd30283,
    16'd26598,16'd45551,C_X,16'd53521,16'd43176,16'd49021,16'd41916,16'd45854,
    16'd42861,16'd50682,16'd46538,C_X,16'd53521,C_X,C_X,C_X,
    16'd26647,16'd27139,16'd45268,16'd28990,16'd42429,16'd45854,C_X,16'd42861,
    16'd26855,16'd45551,16'd51860,16'd42294,16'd42165,16'd53521,16'd53521,16'd45004,
    16'd51860,16'd49768,C_X,C_X,16'd49768,C_X,C_X,C_X,
    16'd26935,16'd43015,16'd47360,C_X,16'd27265,16'd43517,16'd28795,16'd42861,
    16'd19636,16'd26446,16'd41051,16'd23008,16'd26688,16'd45551,16'd23101,16'd923
  };

endpackage

`default_nettype wire

### hdl/bpe_pixel_if.sv
`default_nettype none

interface bpe_pixel_if import bpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               label_bit;
  logic [PIXEL_W-1:0] observed_pixel;
  logic               last_pixel;

  modport source (output valid, label_bit, observed_pixel, last_pixel, input ready);
  modport sink   (input valid, label_bit, observed_pixel, last_pixel, output ready);
endinterface

`default_nettype wire

### hdl/bpe_energy_if.sv
`default_nettype none

interface bpe_energy_if import bpe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] total_energy;
  logic                saturated;

  modport source (output valid, total_energy, saturated, input ready);
  modport sink   (input valid, total_energy, saturated, output ready);
endinterface

`default_nettype wire

### hdl/bpe_line_store.sv
`default_nettype none

module bpe_line_store import bpe_pkg::*; #(
  parameter int DEPTH = DEFAULT_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [1:0]    rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data
);

  // bit 1: upper row, bit 0: middle row
  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/bpe_energy_acc.sv
`default_nettype none
`include "binary_patch_energy_eval_core_macros.svh"

module bpe_energy_acc import bpe_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire acc_ctrl_t        ctrl,
  input  wire logic [ADD_W-1:0] add_value,
  output logic [ENERGY_W-1:0]   sum,
  output logic                  sat_flag
);

  logic [ENERGY_W:0] wide_sum;
  logic              hits_max;

  assign wide_sum = {1'b0, sum} + (ENERGY_W + 1)'(add_value);
  // reaching the maximum exactly counts as saturation
  assign hits_max = wide_sum[ENERGY_W] | (&wide_sum[ENERGY_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum      <= '0;
      sat_flag <= 1'b0;
    end else if (ctrl.add_en) begin
      if (hits_max) begin
        sum      <= ENERGY_MAX;
        sat_flag <= 1'b1;
      end else begin
        sum <= wide_sum[ENERGY_W-1:0];
      end
    end
  end

  `BPE_ASSERT_IMP(a_flag_pins_max, sat_flag, sum == ENERGY_MAX)
  `BPE_ASSERT_NXT(a_clear_empties, ctrl.clear, sum == '0 && !sat_flag)
  `BPE_ASSERT_IMP(a_sum_grows, !$past(rst) && !$past(ctrl.clear), sum >= $past(sum))

endmodule

`default_nettype wire

### hdl/binary_patch_energy_eval_core.sv
// The last pixel's request passes S_MUL, S_UNARY, S_PATCH and S_EMIT before total_energy
//   is valid; S_EMIT waits while the output holds an untaken total. A pixel is taken only
//   in S_IDLE, after the prior pixel's line store read, multiply stages and adds.
// Reset (rst, synchronous, active high) clears the sequencer, counters, window,
//   accumulator and output valid flag, and loads the register defaults.
// Line store is not cleared: at a steady width, complete windows use only written entries.
`default_nettype none
`include "binary_patch_energy_eval_core_macros.svh"

module binary_patch_energy_eval_core import bpe_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  bpe_pixel_if.sink                   pixel,
  bpe_energy_if.source                energy
);

  // Column address width and a compare width that holds both the
  // programmed width and MAX_WIDTH.
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = ((MW_W > IMAGE_WIDTH_W) ? MW_W : IMAGE_WIDTH_W) + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a pixel, issue line store read
  localparam logic [2:0] S_MUL   = 3'd1;  // store data back, unary product, ROM lookup
  localparam logic [2:0] S_UNARY = 3'd2;  // add data term, patch product
  localparam logic [2:0] S_PATCH = 3'd3;  // add patch term
  localparam logic [2:0] S_EMIT  = 3'd4;  // load result, clear image state

  // Configuration registers
  logic [IMAGE_WIDTH_W-1:0] image_width;
  logic [SCALE_W-1:0]       unary_scale;
  logic [SCALE_W-1:0]       clique_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      unary_scale  <= UNARY_SCALE_RESET;
      clique_scale <= CLIQUE_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_UNARY_SCALE:  unary_scale  <= cfg_data[SCALE_W-1:0];
        REG_CLIQUE_SCALE: clique_scale <= cfg_data[SCALE_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Control state
  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] col_count;
  logic [1:0]    row_count;
  logic [5:0]    window;     // [2:0] column two back, [5:3] column one back
  logic          out_valid;

  // Per-pixel payload registers
  logic               label_r;
  logic               last_r;
  logic [CW-1:0]      col_r;
  logic               win_ok_r;
  logic [15:0]        sq_r;
  logic [31:0]        unary_prod;
  logic [ROM_W-1:0]   rom_val;
  logic [31:0]        patch_prod;
  logic [ENERGY_W-1:0] total_r;
  logic               sat_r;

  logic in_fire;
  logic emit_go;

  assign pixel.ready = (state == S_IDLE);
  assign in_fire     = pixel.valid & pixel.ready;
  // Load the result once the output register is free or being drained.
  assign emit_go     = (state == S_EMIT) && (!out_valid || energy.ready);

  // Effective row width: 0 acts as 1, anything above MAX_WIDTH acts as MAX_WIDTH.
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_plus;
  logic             row_end;

  assign width_ext = CMP_W'(image_width);
  always_comb begin
    priority if (width_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
  end
  assign col_plus = CMP_W'(col_count) + CMP_W'(1);
  assign row_end  = (col_plus >= width_eff);

  // Data term difference: |label*255 - observed|
  logic [PIXEL_W-1:0] diff;
  assign diff = pixel.label_bit ? (~pixel.observed_pixel) : pixel.observed_pixel;

  // Line store
  logic [1:0] ls_rd_data;
  logic       ls_we;
  logic       top_bit;
  logic       mid_bit;
  logic [2:0] new_col;
  logic [PATTERN_W-1:0] pattern;

  assign ls_we   = (state == S_MUL);
  assign top_bit = ls_rd_data[1];
  assign mid_bit = ls_rd_data[0];
  assign new_col = {label_r, mid_bit, top_bit};
  // Bit 3*r + c holds row r, column c.
  assign pattern = {new_col[2], window[5], window[2],
                    new_col[1], window[4], window[1],
                    new_col[0], window[3], window[0]};

  bpe_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_count),
    .rd_data (ls_rd_data),
    .wr_en   (ls_we),
    .wr_addr (col_r),
    .wr_data ({mid_bit, label_r})   // middle row moves up, new label becomes middle
  );

  // Accumulator
  acc_ctrl_t            acc_ctrl;
  logic [ADD_W-1:0]     acc_add;
  logic [31:0]          patch_round;
  logic [ENERGY_W-1:0]  acc_sum;
  logic                 acc_sat;

  // Patch product is Q.20; round half up to Q.12. No carry out: the product
  // stays well below 2^32 - 128.
  assign patch_round = patch_prod + 32'd128;

  always_comb begin
    acc_ctrl.add_en = (state == S_UNARY) || ((state == S_PATCH) && win_ok_r);
    acc_ctrl.clear  = emit_go;
    if (state == S_UNARY) begin
      acc_add = {unary_prod, 4'b0000};           // Q.8 to Q.12
    end else begin
      acc_add = ADD_W'(patch_round[31:8]);
    end
  end

  bpe_energy_acc u_energy_acc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (acc_ctrl),
    .add_value (acc_add),
    .sum       (acc_sum),
    .sat_flag  (acc_sat)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_MUL;
      S_MUL:   state_next = S_UNARY;
      S_UNARY: state_next = S_PATCH;
      S_PATCH: state_next = last_r ? S_EMIT : S_IDLE;
      S_EMIT:  if (emit_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position counters and the window; advance on a request, clear at image end.
  always_ff @(posedge clk) begin
    if (rst || emit_go) begin
      col_count <= '0;
      row_count <= '0;
      window    <= '0;
    end else begin
      if (in_fire) begin
        if (row_end) begin
          col_count <= '0;
          if (row_count != 2'd2) begin
            row_count <= row_count + 2'd1;
          end
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
      if (state == S_MUL) begin
        window <= {new_col, window[5:3]};
      end
    end
  end

  // Datapath registers, one multiplier per stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      label_r  <= pixel.label_bit;
      last_r   <= pixel.last_pixel;
      col_r    <= col_count;
      win_ok_r <= (row_count == 2'd2) && (col_count >= CW'(2));
      sq_r     <= diff * diff;
    end
    if (state == S_MUL) begin
      unary_prod <= unary_scale * sq_r;
      rom_val    <= PATCH_ROM[pattern];
    end
    if (state == S_UNARY) begin
      patch_prod <= clique_scale * rom_val;
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (energy.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      total_r <= acc_sum;
      sat_r   <= acc_sat;
    end
  end

  assign energy.valid        = out_valid;
  assign energy.total_energy = total_r;
  assign energy.saturated    = sat_r;

  `BPE_ASSERT_NXT(a_write_follows_read, in_fire, ls_we && col_r == $past(col_count))
  `BPE_ASSERT_IMP(a_emit_only_last, state == S_EMIT, last_r)
  `BPE_ASSERT_NXT(a_emit_loads_output, emit_go, out_valid && total_r == $past(acc_sum))

endmodule

`default_nettype wire

### sim/binary_patch_energy_eval_core_test.sv
`timescale 1ns / 1ps

module binary_patch_energy_eval_core_test;
  import bpe_pkg::*;

  localparam int MAX_W           = DEFAULT_MAX_WIDTH;
  localparam int FILL_W          = 64;      // covers every column that later tests reach
  localparam int DRAIN_CYCLES    = 12;      // outlasts any pixel still in flight
  localparam int HOLD_OFF_CYCLES = 300;     // long enough to back the block up
  localparam int RANDOM_PIXELS   = 720;
  localparam int LIMIT_CYCLES    = 500000;

  typedef struct packed {
    logic [ENERGY_W-1:0] total_energy;
    logic                saturated;
  } image_total_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bpe_pixel_if  pixel_ch ();
  bpe_energy_if energy_ch ();

  binary_patch_energy_eval_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel_ch),
    .energy    (energy_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared bookkeeping. Each counter but error_count has exactly one writer.
  int unsigned  error_count      = 0;
  int unsigned  cycle_count      = 0;
  int unsigned  pixels_sent      = 0;   // written by the request driver
  int unsigned  results_taken    = 0;   // written by the monitor
  int unsigned  hold_offs_issued = 0;   // written by the test sequence
  bit           no_gaps          = 1'b0;

  // Totals the block owes us, oldest first.
  image_total_t pending_totals[$];

  // Energy predictor: its own copy of registers and image state.
  logic [IMAGE_WIDTH_W-1:0] cfg_width;
  logic [SCALE_W-1:0]       cfg_unary;
  logic [SCALE_W-1:0]       cfg_clique;
  bit                       row_above  [MAX_W];
  bit                       row_middle [MAX_W];
  logic [5:0]               window_cols;     // [2:0] two columns back, [5:3] one back
  int unsigned              col_count;
  int unsigned              rows_done;       // saturates at 2
  logic [ENERGY_W-1:0]      energy_acc;
  logic                     energy_sat;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic void clear_image_state();
    window_cols = '0;
    col_count   = 0;
    rows_done   = 0;
    energy_acc  = '0;
    energy_sat  = 1'b0;
  endfunction

  // Saturate once the sum would reach or pass the maximum.
  function automatic void add_energy(input logic [63:0] amount);
    if (amount >= 64'(ENERGY_MAX) - 64'(energy_acc)) begin
      energy_acc = ENERGY_MAX;
      energy_sat = 1'b1;
    end else begin
      energy_acc = energy_acc + amount[ENERGY_W-1:0];
    end
  endfunction

  // Fold one accepted pixel into the running image energy; queue the total
  // when the pixel closes the image.
  function automatic void score_pixel(input logic lb, input logic [PIXEL_W-1:0] grey,
                                      input logic lp);
    int unsigned          span;
    int unsigned          col;
    int unsigned          delta;
    int unsigned          r;
    logic [2:0]           fresh;
    logic [2:0]           oldest;
    logic [2:0]           prior;
    logic [PATTERN_W-1:0] pattern;
    image_total_t         total;
    span  = (cfg_width == '0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
    col   = col_count % MAX_W;
    delta = lb ? (255 - grey) : grey;
    add_energy((64'(cfg_unary) * 64'(delta * delta)) << 4);

    // column under the current pixel: top, middle, bottom
    fresh = {lb, row_middle[col], row_above[col]};
    if (rows_done >= 2 && col_count >= 2) begin
      oldest = window_cols[2:0];
      prior  = window_cols[5:3];
      pattern = '0;
      for (r = 0; r < 3; r++) begin
        pattern[3*r]   = oldest[r];
        pattern[3*r+1] = prior[r];
        pattern[3*r+2] = fresh[r];
      end
      add_energy((64'(cfg_clique) * 64'(PATCH_ROM[pattern]) + 64'd128) >> 8);
    end

    window_cols     = {fresh, window_cols[5:3]};
    row_above[col]  = row_middle[col];
    row_middle[col] = lb;
    if (col_count + 1 >= span) begin
      col_count = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      col_count++;
    end

    if (lp) begin
      total.total_energy = energy_acc;
      total.saturated    = energy_sat;
      pending_totals     = {pending_totals, total};
      clear_image_state();
    end
  endfunction

  // Monitor: check totals, track register writes, predict accepted pixels.
  // Doing them in one process keeps their order fixed.
  always @(posedge clk) begin : monitor
    image_total_t want;
    if (rst) begin
      foreach (row_above[i]) begin
        row_above[i]  = 1'b0;
        row_middle[i] = 1'b0;
      end
      clear_image_state();
      cfg_width  = IMAGE_WIDTH_RESET;
      cfg_unary  = UNARY_SCALE_RESET;
      cfg_clique = CLIQUE_SCALE_RESET;
    end else begin
      if (energy_ch.valid && energy_ch.ready) begin
        results_taken++;
        if (pending_totals.size() == 0) begin
          report_mismatch("total with no image ended", 64'(energy_ch.total_energy), 0);
        end else begin
          want = pending_totals.pop_front();
          if (energy_ch.total_energy !== want.total_energy)
            report_mismatch("total_energy", 64'(energy_ch.total_energy),
                            64'(want.total_energy));
          if (energy_ch.saturated !== want.saturated)
            report_mismatch("saturated", 64'(energy_ch.saturated), 64'(want.saturated));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  cfg_width  = cfg_data[IMAGE_WIDTH_W-1:0];
          REG_UNARY_SCALE:  cfg_unary  = cfg_data;
          REG_CLIQUE_SCALE: cfg_clique = cfg_data;
          default: ;
        endcase
      end
      if (pixel_ch.valid && pixel_ch.ready)
        score_pixel(pixel_ch.label_bit, pixel_ch.observed_pixel, pixel_ch.last_pixel);
    end
  end

  // Result sink: after each accepted total, drop ready for a drawn number of
  // cycles. A hold-off request from the test overrides that for a long stretch.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned taken_seen;
    int unsigned holds_seen;
    energy_ch.ready = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    taken_seen = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_offs_issued) begin
        holds_seen = hold_offs_issued;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (taken_seen != results_taken) begin
        taken_seen = results_taken;
        stall_left = no_gaps ? 0 : $urandom_range(0, 16);
      end
      if (hold_left != 0) begin
        hold_left--;
        energy_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        energy_ch.ready <= 1'b0;
      end else begin
        energy_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one pixel request: idle a drawn number of cycles, then hold the
  // request until the block takes it. Leave valid high so back-to-back
  // requests need no second assignment in the same step.
  task automatic send_pixel(input logic lb, input logic [PIXEL_W-1:0] grey, input logic lp);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid          <= 1'b1;
    pixel_ch.label_bit      <= lb;
    pixel_ch.observed_pixel <= grey;
    pixel_ch.last_pixel     <= lp;
    do @(posedge clk); while (!pixel_ch.ready);
    pixel_sent_count: pixels_sent++;
  endtask

  // Drop the request, wait for every owed total, then let the pipeline drain
  // so a register write cannot land on a pixel still in flight.
  task automatic settle();
    @(negedge clk);
    pixel_ch.valid <= 1'b0;
    while (pending_totals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return UNARY_SCALE_RESET;
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  // One image of 'length' pixels, last flag on the final one. Smooth images
  // keep runs of equal labels so the window sees clean-shape patterns.
  // A nonzero reshape_at changes the width mid-image before that pixel.
  task automatic send_image(input int unsigned length, input bit smooth,
                            input int unsigned reshape_at);
    int unsigned        i;
    logic               lb;
    logic               prev;
    logic [PIXEL_W-1:0] grey;
    prev = 1'($urandom);
    for (i = 0; i < length; i++) begin
      if (i == reshape_at && i != 0) begin
        settle();
        write_register(REG_IMAGE_WIDTH, {5'($urandom), 11'($urandom_range(0, 12))});
      end
      lb   = smooth ? (($urandom_range(0, 7) == 0) ? ~prev : prev) : 1'($urandom);
      prev = lb;
      case ($urandom_range(0, 3))
        0:       grey = lb ? 8'd255 : 8'd0;
        1:       grey = lb ? 8'(255 - $urandom_range(0, 40)) : 8'($urandom_range(0, 40));
        default: grey = 8'($urandom);
      endcase
      send_pixel(lb, grey, i == length - 1);
    end
  endtask

  // Reset defaults on a short partial row, then two whole rows and a few
  // windows at a wide setting. That fills every line store column that later
  // widths reach, so later width changes never read unwritten entries.
  task automatic test_reset_and_fill();
    send_image(12, 1'b1, 0);
    settle();
    write_register(REG_IMAGE_WIDTH, 16'(FILL_W));
    send_image(2 * FILL_W + 6, 1'b1, 0);
  endtask

  // Largest weights, grey extremes against both labels, one complete window.
  task automatic test_field_extremes();
    settle();
    write_register(REG_IMAGE_WIDTH, 16'd3);
    write_register(REG_UNARY_SCALE, '1);
    write_register(REG_CLIQUE_SCALE, '1);
    send_pixel(1'b0, 8'd0,   1'b0);
    send_pixel(1'b0, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd0,   1'b0);
    send_pixel(1'b1, 8'd255, 1'b0);
    send_pixel(1'b0, 8'h55,  1'b0);
    send_pixel(1'b1, 8'hAA,  1'b0);
    send_pixel(1'b1, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd0,   1'b0);
    send_pixel(1'b1, 8'd0,   1'b1);
  endtask

  // Width zero acts as one, widths one and two never complete a window,
  // widths past the line store clamp to it; the last image ends mid-row.
  task automatic test_degenerate_widths();
    settle();
    write_register(REG_IMAGE_WIDTH, 16'd0);
    send_image(3, 1'b0, 0);
    settle();
    write_register(REG_IMAGE_WIDTH, 16'd2);
    write_register(REG_UNARY_SCALE, '0);
    write_register(REG_CLIQUE_SCALE, '0);
    send_image(6, 1'b0, 0);
    settle();
    write_register(REG_IMAGE_WIDTH, '1);    // upper data bits set, width field 2047
    write_register(REG_UNARY_SCALE, UNARY_SCALE_RESET);
    write_register(REG_CLIQUE_SCALE, CLIQUE_SCALE_RESET);
    send_image(4, 1'b0, 0);
  endtask

  // Hold off the result side while short images of width one keep coming, so totals
  // pile up and the block has to stall its pixel input.
  task automatic test_output_backpressure();
    int unsigned i;
    settle();
    write_register(REG_IMAGE_WIDTH, 16'd1);
    write_register(REG_UNARY_SCALE, pick_scale());
    no_gaps = 1'b1;
    hold_offs_issued++;
    for (i = 0; i < 48; i++)
      send_pixel(1'($urandom), 8'($urandom), $urandom_range(0, 3) != 0);
    no_gaps = 1'b0;
  endtask

  // Phases of random settings, each a few images of whole rows and a random tail, with
  // random content; some short, some cut mid-row, some reshaped mid-image.
  task automatic test_random_images();
    int unsigned goal;
    int unsigned images_left;
    int unsigned span;
    int unsigned eff;
    int unsigned rows;
    int unsigned length;
    int unsigned reshape_at;
    goal        = pixels_sent + RANDOM_PIXELS;
    images_left = 0;
    span        = 3;
    while (pixels_sent < goal) begin
      if (images_left == 0) begin
        settle();
        case ($urandom_range(0, 9))
          0:       span = $urandom_range(0, 2);
          1:       span = $urandom_range(13, 48);
          2:       span = $urandom_range(MAX_W + 1, 2047);
          default: span = $urandom_range(3, 10);
        endcase
        write_register(REG_IMAGE_WIDTH, {5'($urandom), 11'(span)});
        write_register(REG_UNARY_SCALE, pick_scale());
        write_register(REG_CLIQUE_SCALE, pick_scale());
        no_gaps     = ($urandom_range(0, 3) == 0);
        images_left = $urandom_range(1, 4);
      end
      images_left--;

      if (span > MAX_W) begin
        length = $urandom_range(1, 12);   // clamped width: keep it to a partial row
      end else begin
        eff  = (span == 0) ? 1 : span;
        rows = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
        if (eff > 12 && rows > 3) rows = 3;
        length = rows * eff + $urandom_range(0, eff - 1);
        if (length == 0) length = 1;
      end
      reshape_at = ($urandom_range(0, 7) == 0 && length > 2) ? $urandom_range(1, length - 1)
                                                             : 0;
      send_image(length, 1'($urandom), reshape_at);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_IMAGE_WIDTH;
    cfg_data                = '0;
    pixel_ch.valid          = 1'b0;
    pixel_ch.label_bit      = 1'b0;
    pixel_ch.observed_pixel = '0;
    pixel_ch.last_pixel     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_and_fill();
    test_field_extremes();
    test_degenerate_widths();
    test_output_backpressure();
    test_random_images();

    // drain, then give the verdict
    settle();
    if (pending_totals.size() != 0)
      report_mismatch("totals still owed at end", 64'(pending_totals.size()), 0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/bpe_pkg.sv
hdl/bpe_pixel_if.sv
hdl/bpe_energy_if.sv
hdl/bpe_line_store.sv
hdl/bpe_energy_acc.sv
hdl/binary_patch_energy_eval_core.sv
sim/binary_patch_energy_eval_core_test.sv
